### hdl/quadratic_root_solver_top_defines.svh
// assertion macros shared by the solver rtl
`ifndef QUADRATIC_ROOT_SOLVER_TOP_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define QRS_ASSERT_IMP(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) else $error(msg);

// next-cycle implication, checked out of reset
`define QRS_ASSERT_NXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);

`endif

### hdl/qrs_pkg.sv
// shared types and constants of the quadratic root solver
`default_nettype none
package qrs_pkg;

  localparam int APB_DW    = 32;
  localparam int ADDR_W    = 3;
  localparam int REG_IDX_W = ADDR_W - 2;
  localparam int TOL_W     = 16;

  localparam logic [REG_IDX_W-1:0] REG_ZERO_TOL = '0;

  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = 2;
  localparam int CNT_W       = 3;

  typedef enum logic [2:0] {
    CASE_TWO_REAL = 3'd0,
    CASE_DOUBLE   = 3'd1,
    CASE_COMPLEX  = 3'd2,
    CASE_LINEAR   = 3'd3,
    CASE_NONE     = 3'd4
  } sol_case_e;

  typedef struct packed {
    logic a_zero;
    logic b_zero;
    logic a_neg;
    logic b_neg;
    logic c_neg;
  } ctl_t;

endpackage
`default_nettype wire

### hdl/qrs_if.sv
// valid/ready channel interfaces for coefficients and roots
`default_nettype none
interface qrs_in_if #(parameter int DW = 32);
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] coef_quadratic;
  logic signed [DW-1:0] coef_linear;
  logic signed [DW-1:0] coef_constant;

  modport source (output valid, output coef_quadratic, output coef_linear,
                  output coef_constant, input ready);
  modport sink   (input valid, input coef_quadratic, input coef_linear,
                  input coef_constant, output ready);
endinterface

interface qrs_out_if #(parameter int DW = 32);
  logic                 valid;
  logic                 ready;
  qrs_pkg::sol_case_e   solution_case;
  logic signed [DW-1:0] root_first;
  logic signed [DW-1:0] root_second;
  logic                 saturated;

  modport source (output valid, output solution_case, output root_first,
                  output root_second, output saturated, input ready);
  modport sink   (input valid, input solution_case, input root_first,
                  input root_second, input saturated, output ready);
endinterface
`default_nettype wire

### hdl/quadratic_root_solver_top.sv
// quadratic root solver: the delay from input to output transfer is set mostly by the
// bit-per-stage square root and dividers
// throughput one coefficient set per cycle while the output side takes results
// a four-entry queue decouples the input side from the stalled datapath
// rst_ni clears the handshake state and zero_tolerance; no clearing pass is needed
`default_nettype none
module quadratic_root_solver_top #(
  parameter int DATA_WIDTH    = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic [qrs_pkg::ADDR_W-1:0] paddr_i,
  input  logic [qrs_pkg::APB_DW-1:0] pwdata_i,
  output logic [qrs_pkg::APB_DW-1:0] prdata_o,
  output logic                       pready_o,
  qrs_in_if.sink                     in_i,
  qrs_out_if.source                  out_o
);
  import qrs_pkg::*;

  localparam int FW = $bits(ctl_t) + 3 * DATA_WIDTH;

  logic                  push_valid, push_ready, pop_valid, pop_ready;
  ctl_t                  ctl_f, ctl_b;
  logic [DATA_WIDTH-1:0] ma_f, mb_f, mc_f, ma_b, mb_b, mc_b;
  logic [TOL_W-1:0]      thr;
  logic [FW-1:0]         pop_data;

  qrs_front #(.DW(DATA_WIDTH)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel_i       (psel_i),
    .penable_i    (penable_i),
    .pwrite_i     (pwrite_i),
    .paddr_i      (paddr_i),
    .pwdata_i     (pwdata_i),
    .prdata_o     (prdata_o),
    .pready_o     (pready_o),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .ctl_o        (ctl_f),
    .ma_o         (ma_f),
    .mb_o         (mb_f),
    .mc_o         (mc_f),
    .thr_o        (thr)
  );

  qrs_fifo #(.WIDTH(FW)) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({ctl_f, ma_f, mb_f, mc_f}),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  assign {ctl_b, ma_b, mb_b, mc_b} = pop_data;

  qrs_back #(.DW(DATA_WIDTH), .FB(FRACTION_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .ctl_i       (ctl_b),
    .ma_i        (ma_b),
    .mb_i        (mb_b),
    .mc_i        (mc_b),
    .thr_i       (thr),
    .out_o       (out_o)
  );

endmodule
`default_nettype wire

### hdl/qrs_front.sv
// front end: config register, coefficient magnitudes and zero classification
`default_nettype none
module qrs_front #(
  parameter int DW = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [qrs_pkg::ADDR_W-1:0]    paddr_i,
  input  logic [qrs_pkg::APB_DW-1:0]    pwdata_i,
  output logic [qrs_pkg::APB_DW-1:0]    prdata_o,
  output logic                          pready_o,
  qrs_in_if.sink                        in_i,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output qrs_pkg::ctl_t                 ctl_o,
  output logic [DW-1:0]                 ma_o,
  output logic [DW-1:0]                 mb_o,
  output logic [DW-1:0]                 mc_o,
  output logic [qrs_pkg::TOL_W-1:0]     thr_o
);
  import qrs_pkg::*;

  logic [TOL_W-1:0] tol_q, tol_d;
  logic             reg_hit;
  logic             wr_en;

  assign pready_o = 1'b1;
  assign reg_hit  = paddr_i[ADDR_W-1:2] == REG_ZERO_TOL;
  assign wr_en    = psel_i && penable_i && pwrite_i && pready_o && reg_hit;
  assign tol_d    = wr_en ? pwdata_i[TOL_W-1:0] : tol_q;
  assign prdata_o = reg_hit ? APB_DW'(tol_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else begin
      tol_q <= tol_d;
    end
  end

  // zero tolerance of zero means exact zero only
  assign thr_o = (tol_q == '0) ? TOL_W'(1) : tol_q;

  assign ma_o = in_i.coef_quadratic[DW-1] ? DW'(-in_i.coef_quadratic) : DW'(in_i.coef_quadratic);
  assign mb_o = in_i.coef_linear[DW-1]    ? DW'(-in_i.coef_linear)    : DW'(in_i.coef_linear);
  assign mc_o = in_i.coef_constant[DW-1]  ? DW'(-in_i.coef_constant)  : DW'(in_i.coef_constant);

  assign ctl_o.a_zero = ma_o < DW'(thr_o);
  assign ctl_o.b_zero = mb_o < DW'(thr_o);
  assign ctl_o.a_neg  = in_i.coef_quadratic[DW-1];
  assign ctl_o.b_neg  = in_i.coef_linear[DW-1];
  assign ctl_o.c_neg  = in_i.coef_constant[DW-1];

  assign push_valid_o = in_i.valid;
  assign in_i.ready   = push_ready_i;

endmodule
`default_nettype wire

### hdl/qrs_fifo.sv
// small queue between front end and datapath
`default_nettype none
`include "quadratic_root_solver_top_defines.svh"
module qrs_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  import qrs_pkg::*;

  logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = cnt_q != CNT_W'(QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = push ? wr_q + PTR_W'(1) : wr_q;
    rd_d  = pop ? rd_q + PTR_W'(1) : rd_q;
    cnt_d = cnt_q + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  `QRS_ASSERT_IMP(a_fifo_cnt, clk_i, rst_ni, 1'b1, cnt_q <= CNT_W'(QUEUE_DEPTH), "fifo overfilled")
  `QRS_ASSERT_NXT(a_fifo_drain, clk_i, rst_ni, pop && !push && cnt_q == CNT_W'(1), !pop_valid_o, "fifo not empty after last pop")

endmodule
`default_nettype wire

### hdl/qrs_sqrt.sv
// pipelined integer square root, one result bit per stage
`default_nettype none
module qrs_sqrt #(
  parameter int IW = 66
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [IW-1:0]   rad_i,
  output logic [IW/2-1:0] root_o
);
  localparam int OW = IW / 2;

  logic [OW-1:0] rem_q  [OW];
  logic [OW-1:0] root_q [OW];
  logic [IW-1:0] rad_q  [OW];

  for (genvar k = 0; k < OW; k++) begin : g_stage
    logic [OW-1:0] rem_in, root_in;
    logic [IW-1:0] rad_in;
    logic [OW+1:0] trial, tst;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end

    assign trial = {rem_in, rad_in[IW-1 -: 2]};
    assign tst   = {root_in, 2'b01};
    assign ge    = trial >= tst;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? OW'(trial - tst) : OW'(trial);
        root_q[k] <= {root_in[OW-2:0], ge};
        rad_q[k]  <= rad_in << 2;
      end
    end
  end

  assign root_o = root_q[OW-1];

endmodule
`default_nettype wire

### hdl/qrs_div.sv
// pipelined restoring divider, (num << FB) / den, one quotient bit per stage
`default_nettype none
module qrs_div #(
  parameter int NW  = 34,
  parameter int DNW = 33,
  parameter int FB  = 16
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [NW-1:0]      num_i,
  input  logic [DNW-1:0]     den_i,
  output logic [NW+FB-1:0]   quo_o
);
  localparam int QW = NW + FB;

  logic [DNW-1:0] rem_q [QW];
  logic [DNW-1:0] den_q [QW];
  logic [QW-1:0]  dvd_q [QW];
  logic [QW-1:0]  quo_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DNW-1:0] rem_in, den_in;
    logic [QW-1:0]  dvd_in, quo_in;
    logic [DNW:0]   trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign den_in = den_i;
      assign dvd_in = QW'(num_i) << FB;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign dvd_in = dvd_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign trial = {rem_in, dvd_in[QW-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? DNW'(trial - {1'b0, den_in}) : DNW'(trial);
        den_q[k] <= den_in;
        dvd_q[k] <= dvd_in << 1;
        quo_q[k] <= {quo_in[QW-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule
`default_nettype wire

### hdl/qrs_back.sv
// back end: discriminant, square root, two dividers and output saturation
`default_nettype none
`include "quadratic_root_solver_top_defines.svh"
module qrs_back #(
  parameter int DW = 32,
  parameter int FB = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      pop_valid_i,
  output logic                      pop_ready_o,
  input  qrs_pkg::ctl_t             ctl_i,
  input  logic [DW-1:0]             ma_i,
  input  logic [DW-1:0]             mb_i,
  input  logic [DW-1:0]             mc_i,
  input  logic [qrs_pkg::TOL_W-1:0] thr_i,
  qrs_out_if.source                 out_o
);
  import qrs_pkg::*;

  localparam int PW  = 2 * DW;
  localparam int RW  = 2 * DW + 2;
  localparam int SR  = RW / 2;
  localparam int NW  = DW + 2;
  localparam int DNW = DW + 1;
  localparam int QW  = NW + FB;
  localparam logic [QW-1:0] LIM = QW'(1) << (DW - 1);

  typedef struct packed {
    sol_case_e     sol;
    ctl_t          ctl;
    logic [DW-1:0] ma;
    logic [DW-1:0] mb;
    logic [DW-1:0] mc;
  } sb_t;

  typedef struct packed {
    sol_case_e sol;
    logic      neg1;
    logic      neg2;
  } tag_t;

  logic en;

  // stage 1: products
  logic          v1_q;
  ctl_t          ctl1_q;
  logic [DW-1:0] ma1_q, mb1_q, mc1_q;
  logic [PW-1:0] bb1_q, ac1_q;

  // stage 2: discriminant and case
  logic          v2_q;
  sb_t           sb2_q, sb2_d;
  logic [RW-1:0] rad2_q, bbx, ac4, dmag;
  logic          dneg;

  // square root stages
  logic [SR-1:0] sv_q;
  sb_t           sbd_q [SR];
  logic [SR-1:0] root;

  // stage 3: numerators and denominators
  logic                  v3_q;
  logic [NW-1:0]         n1_q, n2_q, n1_d, n2_d;
  logic [DNW-1:0]        dn_q, dn_d;
  tag_t                  tg3_q, tg3_d;
  sb_t                   sbx;
  logic signed [DW+2:0]  nb_s, s_x, sum1, sum2;

  // divider stages
  logic [QW-1:0] dv_q;
  tag_t          tgd_q [QW];
  logic [QW-1:0] quo1, quo2;

  // output register
  logic            out_valid_q;
  sol_case_e       case_q;
  logic [DW-1:0]   r1_q, r2_q, r1_d, r2_d;
  logic            sat_q, sat_d;
  logic            sat1, sat2;
  tag_t            tgo;

  function automatic logic [DW:0] sat_enc(input logic [QW-1:0] q, input logic neg);
    logic [QW-1:0] m;
    logic          s;
    logic [DW-1:0] v;
    m = q;
    s = 1'b0;
    if (neg) begin
      if (q > LIM) begin
        m = LIM;
        s = 1'b1;
      end
    end else if (q >= LIM) begin
      m = LIM - QW'(1);
      s = 1'b1;
    end
    v = m[DW-1:0];
    if (neg) begin
      v = -v;
    end
    return {s, v};
  endfunction

  assign en          = !out_valid_q || out_o.ready;
  assign pop_ready_o = en;

  always_comb begin
    bbx = RW'(bb1_q);
    ac4 = RW'(ac1_q) << 2;
    if (ctl1_q.a_neg ^ ctl1_q.c_neg) begin
      dmag = bbx + ac4;
      dneg = 1'b0;
    end else if (bbx >= ac4) begin
      dmag = bbx - ac4;
      dneg = 1'b0;
    end else begin
      dmag = ac4 - bbx;
      dneg = 1'b1;
    end
    sb2_d.ctl = ctl1_q;
    sb2_d.ma  = ma1_q;
    sb2_d.mb  = mb1_q;
    sb2_d.mc  = mc1_q;
    if (ctl1_q.a_zero) begin
      sb2_d.sol = ctl1_q.b_zero ? CASE_NONE : CASE_LINEAR;
    end else if (dneg) begin
      sb2_d.sol = CASE_COMPLEX;
    end else if ((dmag >> FB) < RW'(thr_i)) begin
      sb2_d.sol = CASE_DOUBLE;
    end else begin
      sb2_d.sol = CASE_TWO_REAL;
    end
  end

  qrs_sqrt #(.IW(RW)) u_sqrt (
    .clk_i (clk_i),
    .en_i  (en),
    .rad_i (rad2_q),
    .root_o(root)
  );

  assign sbx  = sbd_q[SR-1];
  assign nb_s = sbx.ctl.b_neg ? signed'({3'b000, sbx.mb}) : -signed'({3'b000, sbx.mb});
  assign s_x  = signed'({2'b00, root});
  assign sum1 = nb_s + s_x;
  assign sum2 = nb_s - s_x;

  always_comb begin
    n1_d      = '0;
    n2_d      = '0;
    dn_d      = {sbx.ma, 1'b0};
    tg3_d.sol = sbx.sol;
    tg3_d.neg1 = 1'b0;
    tg3_d.neg2 = 1'b0;
    case (sbx.sol)
      CASE_LINEAR: begin
        n1_d       = NW'(sbx.mc);
        dn_d       = DNW'(sbx.mb);
        tg3_d.neg1 = !sbx.ctl.c_neg ^ sbx.ctl.b_neg;
      end
      CASE_TWO_REAL: begin
        n1_d       = sum1[DW+2] ? NW'(-sum1) : NW'(sum1);
        n2_d       = sum2[DW+2] ? NW'(-sum2) : NW'(sum2);
        tg3_d.neg1 = sum1[DW+2] ^ sbx.ctl.a_neg;
        tg3_d.neg2 = sum2[DW+2] ^ sbx.ctl.a_neg;
      end
      CASE_DOUBLE: begin
        n1_d       = NW'(sbx.mb);
        tg3_d.neg1 = nb_s[DW+2] ^ sbx.ctl.a_neg;
      end
      CASE_COMPLEX: begin
        n1_d       = NW'(sbx.mb);
        n2_d       = NW'(root);
        tg3_d.neg1 = nb_s[DW+2] ^ sbx.ctl.a_neg;
        tg3_d.neg2 = sbx.ctl.a_neg;
      end
      default: begin
        dn_d = DNW'(1);
      end
    endcase
  end

  qrs_div #(.NW(NW), .DNW(DNW), .FB(FB)) u_div_first (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (n1_q),
    .den_i (dn_q),
    .quo_o (quo1)
  );

  qrs_div #(.NW(NW), .DNW(DNW), .FB(FB)) u_div_second (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (n2_q),
    .den_i (dn_q),
    .quo_o (quo2)
  );

  assign tgo = tgd_q[QW-1];

  always_comb begin
    {sat1, r1_d} = sat_enc(quo1, tgo.neg1);
    {sat2, r2_d} = sat_enc(quo2, tgo.neg2);
    sat_d = sat1 | sat2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      sv_q        <= '0;
      v3_q        <= 1'b0;
      dv_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= pop_valid_i;
      v2_q        <= v1_q;
      sv_q        <= {sv_q[SR-2:0], v2_q};
      v3_q        <= sv_q[SR-1];
      dv_q        <= {dv_q[QW-2:0], v3_q};
      out_valid_q <= dv_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctl1_q   <= ctl_i;
      ma1_q    <= ma_i;
      mb1_q    <= mb_i;
      mc1_q    <= mc_i;
      bb1_q    <= PW'(mb_i) * PW'(mb_i);
      ac1_q    <= PW'(ma_i) * PW'(mc_i);
      sb2_q    <= sb2_d;
      rad2_q   <= dmag;
      sbd_q[0] <= sb2_q;
      for (int k = 1; k < SR; k++) begin
        sbd_q[k] <= sbd_q[k-1];
      end
      n1_q     <= n1_d;
      n2_q     <= n2_d;
      dn_q     <= dn_d;
      tg3_q    <= tg3_d;
      tgd_q[0] <= tg3_q;
      for (int k = 1; k < QW; k++) begin
        tgd_q[k] <= tgd_q[k-1];
      end
      case_q   <= tgo.sol;
      r1_q     <= r1_d;
      r2_q     <= r2_d;
      sat_q    <= sat_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.solution_case = case_q;
  assign out_o.root_first    = signed'(r1_q);
  assign out_o.root_second   = signed'(r2_q);
  assign out_o.saturated     = sat_q;

  `QRS_ASSERT_IMP(a_none_zero, clk_i, rst_ni, out_valid_q && case_q == CASE_NONE, r1_q == '0 && r2_q == '0 && !sat_q, "no-unknown result not zero")
  `QRS_ASSERT_IMP(a_second_unused, clk_i, rst_ni, out_valid_q && (case_q == CASE_DOUBLE || case_q == CASE_LINEAR), r2_q == '0, "unused second root not zero")
  `QRS_ASSERT_NXT(a_pipe_out, clk_i, rst_ni, dv_q[QW-1] && en, out_valid_q, "divider result lost before output")

endmodule
`default_nettype wire
